// ===== hdl/rsst_pkg.sv =====
// rsst_pkg: shared types, request codes and control words for the range sum segment tree.
// No dependencies; used by rsst_ctrl, rsst_dp and range_sum_segment_tree.
`default_nettype none

package rsst_pkg;

    localparam int MAX_ELEMENTS_DEF = 65536;
    localparam int INDEX_W          = 17;
    localparam int DATA_W           = 32;
    localparam int REQ_W            = 2;

    localparam logic [INDEX_W-1:0] COUNT_RESET = 17'h10000;

    localparam logic [REQ_W-1:0] REQ_ADD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SUB = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QRY = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLR = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]          req_type;
        logic [INDEX_W-1:0]        left_index;
        logic [INDEX_W-1:0]        right_index;
        logic signed [DATA_W-1:0]  amount;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  range_sum;
        logic                      range_error;
    } res_t;

    typedef struct packed {
        logic load_upd;
        logic load_qry;
        logic upd_rd;
        logic upd_wr;
        logic q_rd_a;
        logic q_rd_b;
        logic q_shift;
        logic clr_start;
        logic clr_step;
        logic emit_ok;
        logic emit_err;
    } cmd_t;

    typedef struct packed {
        logic upd_ok;
        logic qry_ok;
        logic upd_last;
        logic q_more;
        logic a_odd;
        logic b_odd;
        logic clr_last;
    } stat_t;

endpackage

`default_nettype wire

// ===== hdl/range_sum_segment_tree.sv =====
// range_sum_segment_tree: point update / range sum tree, one request at a time.
// Update: busy while the walk from leaf to root runs; no result word.
// Query: result word once the walk is done, bound by the single memory read port;
// an invalid query answers on the next cycle. Results cannot be stalled.
// Clear and reset run a sweep that zeroes every node word (2*MAX_ELEMENTS, 131072 at default) with busy high.
// Depends on rsst_pkg, rsst_ctrl, rsst_dp.
`default_nettype none

module range_sum_segment_tree
    import rsst_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire req_t               req,
    input  wire logic               cfg_we,
    input  wire logic [INDEX_W-1:0] cfg_wdata,
    output logic                    done,
    output res_t                    result
);

    cmd_t  cmd;
    stat_t stat;

    rsst_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req.req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    rsst_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .result    (result)
    );

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.range_error) |-> (result.range_sum == '0))
        else $error("error word carries nonzero sum");

    a_no_result_update: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req.req_type != REQ_QRY)) |=> !done)
        else $error("result word after non-query request");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result word without pending request");

endmodule

`default_nettype wire

// ===== hdl/rsst_ctrl.sv =====
// rsst_ctrl: sequencer for update walks, range query walks and the clear sweep.
// Depends on rsst_pkg; drives rsst_dp through cmd_t, reads stat_t.
`default_nettype none

module rsst_ctrl
    import rsst_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [REQ_W-1:0] req_type,
    input  wire stat_t            stat,
    output cmd_t                  cmd,
    output logic                  busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLR   = 3'd1;
    localparam logic [2:0] S_URD   = 3'd2;
    localparam logic [2:0] S_UWR   = 3'd3;
    localparam logic [2:0] S_QLOOP = 3'd4;
    localparam logic [2:0] S_QFIN  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (req_type) inside
                        REQ_ADD, REQ_SUB:
                        begin
                            if (stat.upd_ok)
                            begin
                                cmd.load_upd = 1'b1;
                                state_next   = S_URD;
                            end
                        end
                        REQ_QRY:
                        begin
                            if (stat.qry_ok)
                            begin
                                cmd.load_qry = 1'b1;
                                state_next   = S_QLOOP;
                            end
                            else
                            begin
                                cmd.emit_err = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd.clr_start = 1'b1;
                            state_next    = S_CLR;
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_URD:
            begin
                cmd.upd_rd = 1'b1;
                state_next = S_UWR;
            end
            S_UWR:
            begin
                cmd.upd_wr = 1'b1;
                if (stat.upd_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_QLOOP:
            begin
                if (!stat.q_more)
                begin
                    state_next = S_QFIN;
                end
                else if (stat.a_odd)
                begin
                    cmd.q_rd_a = 1'b1;
                end
                else if (stat.b_odd)
                begin
                    cmd.q_rd_b = 1'b1;
                end
                else
                begin
                    cmd.q_shift = 1'b1;
                end
            end
            S_QFIN:
            begin
                cmd.emit_ok = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ===== hdl/rsst_dp.sv =====
// rsst_dp: node sum memory, walk address registers, accumulator and result word register.
// Depends on rsst_pkg; commanded by rsst_ctrl.
`default_nettype none

module rsst_dp
    import rsst_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire req_t               req,
    input  wire logic               cfg_we,
    input  wire logic [INDEX_W-1:0] cfg_wdata,
    input  wire cmd_t               cmd,
    output stat_t                   stat,
    output logic                    done,
    output res_t                    result
);

    localparam int DEPTH = 2 * MAX_ELEMENTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int NW    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int XW    = ((AW + 1 > INDEX_W) ? AW + 1 : INDEX_W) + 1;

    logic [DATA_W-1:0]  mem [DEPTH];
    logic [DATA_W-1:0]  rdata_reg;
    logic [AW-1:0]      raddr;
    logic [AW-1:0]      waddr;
    logic [DATA_W-1:0]  wdata;
    logic               we;

    logic [INDEX_W-1:0] count_reg;
    logic [AW-1:0]      k_reg;
    logic [AW:0]        a_reg;
    logic [AW:0]        b_reg;
    logic [AW:0]        b_dec;
    logic [DATA_W-1:0]  delta_reg;
    logic [DATA_W-1:0]  acc_reg;
    logic [DATA_W-1:0]  acc_next;
    logic               pend_reg;
    logic [AW-1:0]      clr_reg;
    logic               done_reg;
    res_t               res_reg;

    logic [NW-1:0]      n_lim;
    logic [NW-1:0]      count_ext;
    logic [XW-1:0]      leaf_w;
    logic [XW-1:0]      hi_w;

    // active element count, clipped to tree size
    assign count_ext = NW'(count_reg);
    assign n_lim     = (count_ext > NW'(MAX_ELEMENTS)) ? NW'(MAX_ELEMENTS) : count_ext;

    assign leaf_w = XW'(MAX_ELEMENTS) + XW'(req.left_index) - XW'(1);
    assign hi_w   = XW'(MAX_ELEMENTS) + XW'(req.right_index);
    assign b_dec  = b_reg - (AW+1)'(1);

    assign stat.upd_ok   = (req.left_index != '0) && (NW'(req.left_index) <= n_lim);
    assign stat.qry_ok   = (req.left_index != '0) && (NW'(req.right_index) <= n_lim)
                           && (req.left_index <= req.right_index);
    assign stat.upd_last = (k_reg == AW'(1));
    assign stat.q_more   = (a_reg < b_reg);
    assign stat.a_odd    = a_reg[0];
    assign stat.b_odd    = b_reg[0];
    assign stat.clr_last = (clr_reg == AW'(DEPTH - 1));

    assign acc_next = acc_reg + (pend_reg ? rdata_reg : '0);

    always_comb
    begin
        if (cmd.upd_wr)
        begin
            raddr = k_reg >> 1;
        end
        else if (cmd.q_rd_a)
        begin
            raddr = a_reg[AW-1:0];
        end
        else if (cmd.q_rd_b)
        begin
            raddr = b_dec[AW-1:0];
        end
        else
        begin
            raddr = k_reg;
        end
    end

    assign we    = cmd.upd_wr | cmd.clr_step;
    assign waddr = cmd.clr_step ? clr_reg : k_reg;
    assign wdata = cmd.clr_step ? '0 : (rdata_reg + delta_reg);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.upd_rd | cmd.upd_wr | cmd.q_rd_a | cmd.q_rd_b)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            if (cmd.clr_start)
            begin
                clr_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            pend_reg <= cmd.q_rd_a | cmd.q_rd_b;
            done_reg <= cmd.emit_ok | cmd.emit_err;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_upd)
        begin
            k_reg     <= leaf_w[AW-1:0];
            delta_reg <= (req.req_type == REQ_SUB) ? (DATA_W'(0) - req.amount) : req.amount;
        end
        else if (cmd.upd_wr)
        begin
            k_reg <= k_reg >> 1;
        end

        if (cmd.load_qry)
        begin
            a_reg   <= leaf_w[AW:0];
            b_reg   <= hi_w[AW:0];
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (cmd.q_rd_a)
            begin
                a_reg <= a_reg + (AW+1)'(1);
            end
            else if (cmd.q_rd_b)
            begin
                b_reg <= b_dec;
            end
            else if (cmd.q_shift)
            begin
                a_reg <= a_reg >> 1;
                b_reg <= b_reg >> 1;
            end
        end

        if (cmd.emit_ok)
        begin
            res_reg.range_sum   <= acc_next;
            res_reg.range_error <= 1'b0;
        end
        else if (cmd.emit_err)
        begin
            res_reg.range_sum   <= '0;
            res_reg.range_error <= 1'b1;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire
